// ===== sv/aligned_block_cache_lru_core_defines.svh =====
// assertion macros for the block cache tag controller
// used by the port checker; relies on clock and reset in scope
`ifndef ALIGNED_BLOCK_CACHE_LRU_CORE_DEFINES_SVH
`define ALIGNED_BLOCK_CACHE_LRU_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define ABLRU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define ABLRU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ablru_pkg.sv =====
// shared constants, codes and structs for the block cache tag controller
// no dependencies
package ablru_pkg;

   localparam int CACHE_SLOTS  = 16;
   localparam int SLOT_W       = $clog2(CACHE_SLOTS);
   localparam int ISS_W        = $clog2(CACHE_SLOTS + 1);
   localparam int SLOT_FIELD_W = 4;
   localparam int SECTOR_W     = 32;
   localparam int TICK_W       = 32;
   localparam int BLK_W        = 3;
   localparam int COUNT_W      = 4;

   localparam logic [1:0]          MAX_ALIGN_LOG2 = 2'd3;
   localparam logic [SECTOR_W-1:0] LBA28_LIMIT    = 32'h0FFF_FFFF;
   localparam logic [SECTOR_W-1:0] TAG_INVALID    = 32'hFFFF_FFFF;

   // result kinds
   localparam logic [1:0] KIND_HIT  = 2'd0;
   localparam logic [1:0] KIND_FILL = 2'd1;
   localparam logic [1:0] KIND_UNC  = 2'd2;
   localparam logic [1:0] KIND_ERR  = 2'd3;

   // configuration register indexes
   localparam logic CSR_ALIGN = 1'b0;
   localparam logic CSR_WIDE  = 1'b1;

   typedef struct packed {
      logic              done;
      logic              found;
      logic [SLOT_W-1:0] found_idx;
      logic [SLOT_W-1:0] min_idx;
   } scan_res_type;

   typedef struct packed {
      logic                tag_en;
      logic                age_en;
      logic [SLOT_W-1:0]   idx;
      logic [SECTOR_W-1:0] tag;
      logic [TICK_W-1:0]   age;
   } slot_wr_type;

endpackage

// ===== sv/aligned_block_cache_lru_core.sv =====
// Tag and LRU replacement controller for a 16-slot fully associative block cache.
// Requests come in on req_valid/req_stall with req_sector and req_use_cache; the
// block answers with one or more result beats on rsp_valid/rsp_stall, the final
// one flagged by rsp_last. Configuration is written through csr_we/csr_index/
// csr_wdata (index 0 alignment, index 1 wide addressing); the user must write it
// only while the block is idle, which the block itself does not enforce. Tags
// and ages sit in synchronous memories; every lookup is a scan over all 16 slots
// through the single read port. Cached hit: one beat. Cached miss: one hit scan,
// the check state, then per block of the group one scan whose update step starts
// the next scan. Uncached: one beat per block, no scan. Out-of-range sector: one
// error beat, unless a cached request hits first.
// One request is in work at a time; req_stall is high until its last beat has been
// loaded into the output register, so the next request is taken while that beat
// still waits for the receiver. A stalled receiver freezes the sequence in place.
// Synchronous reset empties all slots (per-entry valid bits, no clearing pass),
// clears the tick counter and the configuration, and drops any pending beat.
module aligned_block_cache_lru_core
   import ablru_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  logic                    csr_index,
   input  logic [1:0]              csr_wdata,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [SECTOR_W-1:0]     req_sector,
   input  logic                    req_use_cache,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_kind,
   output logic [SECTOR_W-1:0]     rsp_block_sector,
   output logic [SLOT_FIELD_W-1:0] rsp_slot,
   output logic                    rsp_is_requested,
   output logic [SECTOR_W-1:0]     rsp_read_start,
   output logic [COUNT_W-1:0]      rsp_read_count,
   output logic                    rsp_last
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HSCAN = 3'd1;
   localparam logic [2:0] ST_HDEC  = 3'd2;
   localparam logic [2:0] ST_CHK   = 3'd3;
   localparam logic [2:0] ST_BSCAN = 3'd4;
   localparam logic [2:0] ST_BDEC  = 3'd5;
   localparam logic [2:0] ST_UNC   = 3'd6;
   localparam logic [2:0] ST_ERR   = 3'd7;

   logic [2:0]          state_ff, state_in;
   logic [1:0]          align_ff, align_in;
   logic                wide_ff, wide_in;
   logic [SECTOR_W-1:0] sector_ff, sector_in;
   logic                cached_ff, cached_in;
   logic [SECTOR_W-1:0] start_ff, start_in;
   logic [COUNT_W-1:0]  n_ff, n_in;
   logic [BLK_W-1:0]    b_ff, b_in;
   logic [TICK_W-1:0]   tick_ff, tick_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              kind_ff, kind_in;
   logic [SECTOR_W-1:0]     blk_sec_ff, blk_sec_in;
   logic [SLOT_FIELD_W-1:0] slot_ff, slot_in;
   logic                    isreq_ff, isreq_in;
   logic [SECTOR_W-1:0]     rstart_ff, rstart_in;
   logic [COUNT_W-1:0]      rcount_ff, rcount_in;
   logic                    last_ff, last_in;

   logic                accept;
   logic                out_free;
   logic                out_load;
   logic [1:0]          eff_align;
   logic [COUNT_W-1:0]  n_req;
   logic [SECTOR_W-1:0] blk;
   logic [SECTOR_W-1:0] blk_next;
   logic                is_req;
   logic                last_blk;
   logic                range_err;
   logic [SLOT_W-1:0]   fill_idx;
   logic [TICK_W-1:0]   stamp;

   logic                scan_start;
   logic [SECTOR_W-1:0] scan_target;
   logic                rd_en;
   logic [SLOT_W-1:0]   rd_addr;
   logic [SECTOR_W-1:0] rd_tag;
   logic [TICK_W-1:0]   rd_age;
   scan_res_type        scan_res;
   slot_wr_type         wr;

   ablru_slot_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_tag  (rd_tag),
      .rd_age  (rd_age),
      .wr      (wr)
   );

   ablru_scan u_scan (
      .clock   (clock),
      .reset   (reset),
      .start   (scan_start),
      .target  (scan_target),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_tag  (rd_tag),
      .rd_age  (rd_age),
      .res     (scan_res)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign eff_align = (align_ff > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : align_ff;
   assign n_req     = COUNT_W'(4'd1 << eff_align);
   assign blk       = start_ff + SECTOR_W'(b_ff);
   assign blk_next  = start_ff + SECTOR_W'(b_ff) + SECTOR_W'(1);
   assign is_req    = (blk == sector_ff);
   assign last_blk  = ({1'b0, b_ff} == (n_ff - COUNT_W'(1)));
   assign range_err = !wide_ff && (sector_ff > LBA28_LIMIT);
   // a block already present is refreshed with a pre-incremented tick
   assign fill_idx  = scan_res.found ? scan_res.found_idx : scan_res.min_idx;
   assign stamp     = scan_res.found ? (tick_ff + TICK_W'(1)) : tick_ff;

   always_comb begin
      align_in = align_ff;
      wide_in  = wide_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ALIGN: align_in = csr_wdata;
            CSR_WIDE:  wide_in  = csr_wdata[0];
            default:   align_in = align_ff;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      sector_in   = sector_ff;
      cached_in   = cached_ff;
      start_in    = start_ff;
      n_in        = n_ff;
      b_in        = b_ff;
      tick_in     = tick_ff;
      scan_start  = 1'b0;
      scan_target = blk_next;
      wr          = '0;
      out_load    = 1'b0;
      kind_in     = kind_ff;
      blk_sec_in  = blk_sec_ff;
      slot_in     = slot_ff;
      isreq_in    = isreq_ff;
      rstart_in   = rstart_ff;
      rcount_in   = rcount_ff;
      last_in     = last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sector_in = req_sector;
               cached_in = req_use_cache;
               n_in      = n_req;
               start_in  = req_sector & ~(SECTOR_W'(n_req) - SECTOR_W'(1));
               b_in      = '0;
               if (req_use_cache) begin
                  scan_start  = 1'b1;
                  scan_target = req_sector;
                  state_in    = ST_HSCAN;
               end else begin
                  state_in = ST_CHK;
               end
            end
         end
         ST_HSCAN: begin
            if (scan_res.done) begin
               state_in = ST_HDEC;
            end
         end
         ST_HDEC: begin
            if (!scan_res.found) begin
               state_in = ST_CHK;
            end else if (out_free) begin
               tick_in    = tick_ff + TICK_W'(1);
               wr.age_en  = 1'b1;
               wr.idx     = scan_res.found_idx;
               wr.age     = tick_ff + TICK_W'(1);
               out_load   = 1'b1;
               kind_in    = KIND_HIT;
               blk_sec_in = sector_ff;
               slot_in    = SLOT_FIELD_W'(scan_res.found_idx);
               isreq_in   = 1'b1;
               rstart_in  = '0;
               rcount_in  = '0;
               last_in    = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_CHK: begin
            priority if (range_err) begin
               state_in = ST_ERR;
            end else if (cached_ff) begin
               scan_start  = 1'b1;
               scan_target = start_ff;
               state_in    = ST_BSCAN;
            end else begin
               state_in = ST_UNC;
            end
         end
         ST_BSCAN: begin
            if (scan_res.done) begin
               state_in = ST_BDEC;
            end
         end
         ST_BDEC: begin
            if (out_free) begin
               wr.tag_en  = 1'b1;
               wr.age_en  = 1'b1;
               wr.idx     = fill_idx;
               wr.tag     = blk;
               wr.age     = stamp;
               out_load   = 1'b1;
               kind_in    = KIND_FILL;
               blk_sec_in = blk;
               slot_in    = SLOT_FIELD_W'(fill_idx);
               isreq_in   = is_req;
               rstart_in  = start_ff;
               rcount_in  = n_ff;
               last_in    = last_blk;
               if (last_blk) begin
                  // group done: one more tick for the whole fill
                  tick_in  = stamp + TICK_W'(1);
                  state_in = ST_IDLE;
               end else begin
                  tick_in    = stamp;
                  b_in       = b_ff + BLK_W'(1);
                  scan_start = 1'b1;
                  state_in   = ST_BSCAN;
               end
            end
         end
         ST_UNC: begin
            if (out_free) begin
               out_load   = 1'b1;
               kind_in    = KIND_UNC;
               blk_sec_in = blk;
               slot_in    = '0;
               isreq_in   = is_req;
               rstart_in  = start_ff;
               rcount_in  = n_ff;
               last_in    = last_blk;
               if (last_blk) begin
                  state_in = ST_IDLE;
               end else begin
                  b_in = b_ff + BLK_W'(1);
               end
            end
         end
         ST_ERR: begin
            if (out_free) begin
               out_load   = 1'b1;
               kind_in    = KIND_ERR;
               blk_sec_in = sector_ff;
               slot_in    = '0;
               isreq_in   = 1'b1;
               rstart_in  = '0;
               rcount_in  = '0;
               last_in    = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      priority if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         align_ff     <= '0;
         wide_ff      <= 1'b0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         align_ff     <= align_in;
         wide_ff      <= wide_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sector_ff  <= sector_in;
      cached_ff  <= cached_in;
      start_ff   <= start_in;
      n_ff       <= n_in;
      b_ff       <= b_in;
      kind_ff    <= kind_in;
      blk_sec_ff <= blk_sec_in;
      slot_ff    <= slot_in;
      isreq_ff   <= isreq_in;
      rstart_ff  <= rstart_in;
      rcount_ff  <= rcount_in;
      last_ff    <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = kind_ff;
   assign rsp_block_sector = blk_sec_ff;
   assign rsp_slot         = slot_ff;
   assign rsp_is_requested = isreq_ff;
   assign rsp_read_start   = rstart_ff;
   assign rsp_read_count   = rcount_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== sv/ablru_slot_mem.sv =====
// tag and age memories, one read port with registered data, one write port
// per-entry valid bits give the reset values of never-written entries; uses ablru_pkg
module ablru_slot_mem
   import ablru_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                rd_en,
   input  logic [SLOT_W-1:0]   rd_addr,
   output logic [SECTOR_W-1:0] rd_tag,
   output logic [TICK_W-1:0]   rd_age,
   input  slot_wr_type         wr
);

   logic [SECTOR_W-1:0]    tag_mem [CACHE_SLOTS];
   logic [TICK_W-1:0]      age_mem [CACHE_SLOTS];
   logic [CACHE_SLOTS-1:0] valid_ff;
   logic [CACHE_SLOTS-1:0] valid_in;
   logic [SECTOR_W-1:0]    rd_tag_ff;
   logic [TICK_W-1:0]      rd_age_ff;
   logic                   rd_vld_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.tag_en || wr.age_en) begin
         valid_in[wr.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.tag_en) begin
         tag_mem[wr.idx] <= wr.tag;
      end
      if (wr.age_en) begin
         age_mem[wr.idx] <= wr.age;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff <= tag_mem[rd_addr];
         rd_age_ff <= age_mem[rd_addr];
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   // unwritten entries read as invalid tag and zero age
   assign rd_tag = rd_vld_ff ? rd_tag_ff : TAG_INVALID;
   assign rd_age = rd_vld_ff ? rd_age_ff : '0;

endmodule

// ===== sv/ablru_scan.sv =====
// sequential scan over all slots: first tag match and first slot of least age
// drives the memory read port; uses ablru_pkg
module ablru_scan
   import ablru_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SECTOR_W-1:0] target,
   output logic                rd_en,
   output logic [SLOT_W-1:0]   rd_addr,
   input  logic [SECTOR_W-1:0] rd_tag,
   input  logic [TICK_W-1:0]   rd_age,
   output scan_res_type        res
);

   logic                busy_ff, busy_in;
   logic [ISS_W-1:0]    iss_ff, iss_in;
   logic                dv_ff, dv_in;
   logic [SLOT_W-1:0]   didx_ff, didx_in;
   logic                done_ff, done_in;
   logic [SECTOR_W-1:0] target_ff, target_in;
   logic                found_ff, found_in;
   logic [SLOT_W-1:0]   fidx_ff, fidx_in;
   logic [SLOT_W-1:0]   midx_ff, midx_in;
   logic [TICK_W-1:0]   min_age_ff, min_age_in;
   logic                hit;

   assign rd_en   = busy_ff && (iss_ff < ISS_W'(CACHE_SLOTS));
   assign rd_addr = iss_ff[SLOT_W-1:0];
   // the all-ones tag marks an empty slot and never matches
   assign hit     = (rd_tag == target_ff) && (target_ff != TAG_INVALID);

   always_comb begin
      busy_in    = busy_ff;
      iss_in     = iss_ff;
      dv_in      = rd_en;
      didx_in    = rd_addr;
      done_in    = dv_ff && (didx_ff == SLOT_W'(CACHE_SLOTS - 1));
      target_in  = target_ff;
      found_in   = found_ff;
      fidx_in    = fidx_ff;
      midx_in    = midx_ff;
      min_age_in = min_age_ff;
      if (dv_ff) begin
         if (!found_ff && hit) begin
            found_in = 1'b1;
            fidx_in  = didx_ff;
         end
         if ((didx_ff == '0) || (rd_age < min_age_ff)) begin
            midx_in    = didx_ff;
            min_age_in = rd_age;
         end
      end
      if (rd_en) begin
         iss_in = iss_ff + ISS_W'(1);
      end
      if (done_in) begin
         busy_in = 1'b0;
      end
      if (start) begin
         busy_in   = 1'b1;
         iss_in    = '0;
         target_in = target;
         found_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         dv_ff   <= 1'b0;
         done_ff <= 1'b0;
         iss_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         dv_ff   <= dv_in;
         done_ff <= done_in;
         iss_ff  <= iss_in;
      end
   end

   always_ff @(posedge clock) begin
      didx_ff    <= didx_in;
      target_ff  <= target_in;
      found_ff   <= found_in;
      fidx_ff    <= fidx_in;
      midx_ff    <= midx_in;
      min_age_ff <= min_age_in;
   end

   assign res.done      = done_ff;
   assign res.found     = found_ff;
   assign res.found_idx = fidx_ff;
   assign res.min_idx   = midx_ff;

endmodule

// ===== sv/ablru_checker.sv =====
// port-level checks for the block cache tag controller, bound to the top level
// uses ablru_pkg and aligned_block_cache_lru_core_defines.svh
`include "aligned_block_cache_lru_core_defines.svh"

module ablru_checker
   import ablru_pkg::*;
(
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [1:0]              rsp_kind,
   input logic [SECTOR_W-1:0]     rsp_block_sector,
   input logic [SLOT_FIELD_W-1:0] rsp_slot,
   input logic                    rsp_is_requested,
   input logic [SECTOR_W-1:0]     rsp_read_start,
   input logic [COUNT_W-1:0]      rsp_read_count,
   input logic                    rsp_last
);

   // a held result beat keeps its kind, block sector and last flag
   `ABLRU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_kind) && $stable(rsp_block_sector) && $stable(rsp_last), "stalled result beat changed")

   // a hit closes its request on the requested sector, no drive read
   `ABLRU_ASSERT_NOW(a_hit_shape, rsp_valid && rsp_kind == KIND_HIT, rsp_last && rsp_is_requested && rsp_read_count == '0, "malformed hit beat")

   // an error beat carries no slot and no drive read
   `ABLRU_ASSERT_NOW(a_err_shape, rsp_valid && rsp_kind == KIND_ERR, rsp_last && rsp_slot == '0 && rsp_read_count == '0, "malformed error beat")

   // a block beat lies inside its drive read window
   `ABLRU_ASSERT_NOW(a_blk_window, rsp_valid && rsp_read_count != '0, (rsp_block_sector - rsp_read_start) < SECTOR_W'(rsp_read_count), "block outside read window")

endmodule

bind aligned_block_cache_lru_core ablru_checker u_ablru_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_kind         (rsp_kind),
   .rsp_block_sector (rsp_block_sector),
   .rsp_slot         (rsp_slot),
   .rsp_is_requested (rsp_is_requested),
   .rsp_read_start   (rsp_read_start),
   .rsp_read_count   (rsp_read_count),
   .rsp_last         (rsp_last)
);
